// ===== rtl/swd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swd_pkg
// Shared types and constants of the serial wire debug transfer engine.
// ----------------------------------------------------------------------------
package swd_pkg;

	localparam int DATA_BITS   = 32;
	localparam int HEADER_BITS = 8;
	localparam int REQ_W       = 4;
	// wide enough for the longest phase, including the largest 8-bit idle setting
	localparam int COUNT_W     = 8;
	localparam int QUEUE_DEPTH = 4;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_TURNAROUND = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DATA_ON_WAIT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_IDLE_CYCLES = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RETRY_LIMIT = 2'd3;

	// acknowledge codes
	localparam logic [2:0] ACK_NONE   = 3'd0;
	localparam logic [2:0] ACK_OK     = 3'd1;
	localparam logic [2:0] ACK_WAIT   = 3'd2;
	localparam logic [2:0] ACK_FAULT  = 3'd4;
	localparam logic [2:0] ACK_PARITY = 3'd7;

	typedef enum logic {
		KIND_START = 1'b0,
		KIND_TICK  = 1'b1
	} item_kind_t;

	// classified item as it travels through the queue
	typedef struct packed {
		item_kind_t                 kind;
		logic [REQ_W-1:0]           req;      // bit0 ap, bit1 read, bits 3:2 address
		logic [HEADER_BITS-1:0]     hdr;
		logic [DATA_BITS-1:0]       wdata;
		logic                       line_in;
	} swd_item_t;

	typedef struct packed {
		logic                 clock_pulse;
		logic                 line_out;
		logic                 line_drive;
		logic                 done_res;
		logic [2:0]           ack_code;
		logic [DATA_BITS-1:0] read_data;
		logic                 parity_error;
	} swd_result_t;

	typedef struct packed {
		logic [2:0]  turnaround_cycles;
		logic        data_phase_on_wait;
		logic [7:0]  idle_cycles;
		logic [15:0] wait_retry_limit;
	} swd_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/swd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swd_front
// Accepts stream items, builds the request header and queues the items.
// ----------------------------------------------------------------------------
module swd_front #(
	parameter int DEPTH = swd_pkg::QUEUE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// ap_access, read_access, reg_addr[1:0], write_data[31:0], line_in, zero pad
	input  wire logic [swd_pkg::S_TDATA_W-1:0] s_tdata,
	// action
	input  wire logic                          s_tuser,
	output logic                               item_valid,
	input  wire logic                          item_ready,
	output swd_pkg::swd_item_t                 item
);
	import swd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	swd_item_t         queue_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	swd_item_t         new_item;
	logic              push;
	logic              pop;
	logic [REQ_W-1:0]  req;
	logic              hdr_par;

	// request bits and header parity over those four bits only
	assign req     = {s_tdata[3:2], s_tdata[1], s_tdata[0]};
	assign hdr_par = ^req;

	always_comb begin
		new_item.kind    = item_kind_t'(s_tuser);
		new_item.req     = req;
		new_item.hdr     = {1'b1, 1'b0, hdr_par, req, 1'b1};
		new_item.wdata   = s_tdata[35:4];
		new_item.line_in = s_tdata[36];
	end

	assign s_tready   = (cnt_q != CNT_W'(DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = queue_q[rd_ptr_q];
	assign push       = s_tvalid && s_tready;
	assign pop        = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/swd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swd_back
// Line sequencer: runs header, turnaround, acknowledge, data, back-off,
// error and idle phases one line cycle per tick, and registers the result.
// ----------------------------------------------------------------------------
module swd_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	input  wire logic [swd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [swd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire swd_pkg::swd_item_t              item,
	output logic                                 res_valid,
	input  wire logic                            res_ready,
	output swd_pkg::swd_result_t                 res
);
	import swd_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_HDR,
		PH_TRNA,
		PH_ACK,
		PH_RDATA,
		PH_RPAR,
		PH_RTRN,
		PH_WTRN,
		PH_WDATA,
		PH_WPAR,
		PH_IDLECYC,
		PH_BOREAD,
		PH_BOTRN,
		PH_BOWRITE,
		PH_ERR
	} phase_t;

	localparam logic [COUNT_W-1:0] LEN_HDR  = COUNT_W'(HEADER_BITS);
	localparam logic [COUNT_W-1:0] LEN_DATA = COUNT_W'(DATA_BITS);
	localparam logic [COUNT_W-1:0] LEN_DPAR = COUNT_W'(DATA_BITS + 1);
	localparam logic [COUNT_W-1:0] LEN_ACK  = COUNT_W'(3);
	localparam logic [COUNT_W-1:0] LEN_ONE  = COUNT_W'(1);

	swd_cfg_t               cfg_q;
	phase_t                 phase_q, phase_n;
	logic [COUNT_W-1:0]     count_q, count_n;
	logic [DATA_BITS-1:0]   shift_q, shift_n;
	logic [DATA_BITS-1:0]   held_q, held_n;
	logic [REQ_W-1:0]       req_q, req_n;
	logic [HEADER_BITS-1:0] hdr_q, hdr_n;
	logic [2:0]             ack_q, ack_n;
	logic                   par_q, par_n;
	logic [15:0]            att_q, att_n;
	logic                   res_valid_q;
	swd_result_t            res_q, res_n;

	logic                   take;
	logic                   is_rd;
	logic                   tc_nz;
	logic [COUNT_W-1:0]     tc_len;
	logic [COUNT_W-1:0]     count_dec;
	logic [15:0]            att_inc;
	logic                   bo_start, bw_chain, retry_chk, idle_chain, fin;

	assign take       = item_valid && (!res_valid_q || res_ready);
	assign item_ready = take;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	assign is_rd     = req_q[1];
	assign tc_nz     = (cfg_q.turnaround_cycles != '0);
	assign tc_len    = COUNT_W'(cfg_q.turnaround_cycles);
	assign count_dec = count_q - 1'b1;
	assign att_inc   = (att_q != 16'hFFFF) ? att_q + 16'd1 : att_q;

	always_comb begin
		phase_n    = phase_q;
		count_n    = count_q;
		shift_n    = shift_q;
		held_n     = held_q;
		req_n      = req_q;
		hdr_n      = hdr_q;
		ack_n      = ack_q;
		par_n      = par_q;
		att_n      = att_q;
		res_n      = '0;
		bo_start   = 1'b0;
		bw_chain   = 1'b0;
		retry_chk  = 1'b0;
		idle_chain = 1'b0;
		fin        = 1'b0;

		if (item.kind == KIND_START) begin
			req_n   = item.req;
			hdr_n   = item.hdr;
			held_n  = item.wdata;
			shift_n = item.wdata;
			att_n   = '0;
			par_n   = 1'b0;
			ack_n   = ACK_NONE;
			if (cfg_q.wait_retry_limit == '0) begin
				phase_n       = PH_IDLE;
				count_n       = '0;
				res_n.done_res = 1'b1;
			end else begin
				phase_n = PH_HDR;
				count_n = LEN_HDR;
			end
		end else if (phase_q != PH_IDLE && count_q != '0) begin
			res_n.clock_pulse = 1'b1;
			case (phase_q)
				PH_HDR: begin
					res_n.line_out   = hdr_q[0];
					res_n.line_drive = 1'b1;
					// rotate so the header is back in place for a retry
					hdr_n            = {hdr_q[0], hdr_q[HEADER_BITS-1:1]};
				end
				PH_ACK: begin
					ack_n = {item.line_in, ack_q[2:1]};
				end
				PH_RDATA: begin
					shift_n = {item.line_in, shift_q[DATA_BITS-1:1]};
					par_n   = par_q ^ item.line_in;
				end
				PH_RPAR: begin
					par_n = par_q ^ item.line_in;
				end
				PH_WDATA: begin
					res_n.line_out   = shift_q[0];
					res_n.line_drive = 1'b1;
					par_n            = par_q ^ shift_q[0];
					shift_n          = {1'b0, shift_q[DATA_BITS-1:1]};
				end
				PH_WPAR: begin
					res_n.line_out   = par_q;
					res_n.line_drive = 1'b1;
				end
				PH_IDLECYC, PH_BOWRITE: begin
					res_n.line_drive = 1'b1;
				end
				default: begin
				end
			endcase

			count_n = count_dec;
			if (count_dec == '0) begin
				// pick the next phase, skipping those of zero length
				case (phase_q)
					PH_HDR: begin
						phase_n = tc_nz ? PH_TRNA : PH_ACK;
						count_n = tc_nz ? tc_len : LEN_ACK;
					end
					PH_TRNA: begin
						phase_n = PH_ACK;
						count_n = LEN_ACK;
					end
					PH_ACK: begin
						if (ack_n == ACK_OK) begin
							if (is_rd) begin
								phase_n = PH_RDATA;
								count_n = LEN_DATA;
							end else begin
								phase_n = tc_nz ? PH_WTRN : PH_WDATA;
								count_n = tc_nz ? tc_len : LEN_DATA;
							end
						end else if (ack_n == ACK_WAIT || ack_n == ACK_FAULT) begin
							bo_start = 1'b1;
						end else begin
							phase_n = PH_ERR;
							count_n = tc_len + LEN_DPAR;
						end
					end
					PH_RDATA: begin
						phase_n = PH_RPAR;
						count_n = LEN_ONE;
					end
					PH_RPAR: begin
						if (tc_nz) begin
							phase_n = PH_RTRN;
							count_n = tc_len;
						end else begin
							idle_chain = 1'b1;
						end
					end
					PH_RTRN, PH_WPAR: begin
						idle_chain = 1'b1;
					end
					PH_WTRN: begin
						phase_n = PH_WDATA;
						count_n = LEN_DATA;
					end
					PH_WDATA: begin
						phase_n = PH_WPAR;
						count_n = LEN_ONE;
					end
					PH_BOREAD: begin
						if (tc_nz) begin
							phase_n = PH_BOTRN;
							count_n = tc_len;
						end else begin
							bw_chain = 1'b1;
						end
					end
					PH_BOTRN: begin
						bw_chain = 1'b1;
					end
					PH_BOWRITE: begin
						retry_chk = 1'b1;
					end
					default: begin
						fin = 1'b1;
					end
				endcase

				if (bo_start) begin
					if (cfg_q.data_phase_on_wait && is_rd) begin
						phase_n = PH_BOREAD;
						count_n = LEN_DPAR;
					end else if (tc_nz) begin
						phase_n = PH_BOTRN;
						count_n = tc_len;
					end else begin
						bw_chain = 1'b1;
					end
				end
				if (bw_chain) begin
					if (cfg_q.data_phase_on_wait && !is_rd) begin
						phase_n = PH_BOWRITE;
						count_n = LEN_DPAR;
					end else begin
						retry_chk = 1'b1;
					end
				end
				if (retry_chk) begin
					if (ack_n == ACK_WAIT) begin
						att_n = att_inc;
						if (att_inc < cfg_q.wait_retry_limit) begin
							phase_n = PH_HDR;
							count_n = LEN_HDR;
							shift_n = held_q;
							par_n   = 1'b0;
							ack_n   = ACK_NONE;
						end else begin
							fin = 1'b1;
						end
					end else begin
						fin = 1'b1;
					end
				end
				if (idle_chain) begin
					if (cfg_q.idle_cycles != '0) begin
						phase_n = PH_IDLECYC;
						count_n = COUNT_W'(cfg_q.idle_cycles);
					end else begin
						fin = 1'b1;
					end
				end

				if (fin) begin
					phase_n        = PH_IDLE;
					count_n        = '0;
					res_n.done_res = 1'b1;
					if (ack_n == ACK_OK) begin
						if (is_rd && par_n) begin
							res_n.ack_code     = ACK_PARITY;
							res_n.parity_error = 1'b1;
						end else begin
							res_n.ack_code  = ACK_OK;
							res_n.read_data = is_rd ? shift_n : '0;
						end
					end else begin
						res_n.ack_code = ack_n;
					end
				end
			end
		end else begin
			phase_n = PH_IDLE;
			count_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.turnaround_cycles  <= 3'd1;
			cfg_q.data_phase_on_wait <= 1'b0;
			cfg_q.idle_cycles        <= 8'd0;
			cfg_q.wait_retry_limit   <= 16'd100;
			phase_q                  <= PH_IDLE;
			count_q                  <= '0;
			res_valid_q              <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_TURNAROUND:   cfg_q.turnaround_cycles  <= cfg_data[2:0];
					REG_DATA_ON_WAIT: cfg_q.data_phase_on_wait <= cfg_data[0];
					REG_IDLE_CYCLES:  cfg_q.idle_cycles        <= cfg_data[7:0];
					REG_RETRY_LIMIT:  cfg_q.wait_retry_limit   <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
			if (take) begin
				phase_q     <= phase_n;
				count_q     <= count_n;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			shift_q <= shift_n;
			held_q  <= held_n;
			req_q   <= req_n;
			hdr_q   <= hdr_n;
			ack_q   <= ack_n;
			par_q   <= par_n;
			att_q   <= att_n;
			res_q   <= res_n;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/swd_transfer_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swd_transfer_engine
// Serial wire debug master that carries out one register access per start.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result. A start item latches the
// request and write word; each tick item is one line clock cycle and reports
// clock, level and drive of the data line, with done on the last cycle of the
// whole transfer, retries included. The front queues up to QUEUE_DEPTH items;
// the sequencer takes one item per clock while its output register is free
// or read, placing the result there; items stream at one per clock when no
// side stalls, via queue and output register. The user must write registers
// via cfg port only while no transfer is in flight; the block does not check.
module swd_transfer_engine #(
	parameter int QUEUE_DEPTH = swd_pkg::QUEUE_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// ap_access, read_access, reg_addr[1:0], write_data[31:0], line_in, zero pad
	input  wire logic [swd_pkg::S_TDATA_W-1:0]   s_tdata,
	// action
	input  wire logic                            s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// clock_pulse, line_out, line_drive, ack_code[2:0], read_data[31:0],
	// parity_error, zero pad
	output logic [swd_pkg::M_TDATA_W-1:0]        m_tdata,
	// done_res
	output logic                                 m_tlast,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [swd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [swd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import swd_pkg::*;

	swd_item_t   item;
	logic        item_valid;
	logic        item_ready;
	swd_result_t res;

	assign cfg_ready = 1'b1;

	swd_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	swd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = {1'b0, res.parity_error, res.read_data, res.ack_code,
		res.line_drive, res.line_out, res.clock_pulse};
	assign m_tlast = res.done_res;

endmodule
`default_nettype wire
